// File: rtl/mhtq_pkg.sv
package mhtq_pkg;
  localparam int Capacity = 64;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int DueW = 48;
  localparam int TagW = 16;
  localparam int OccW = 7;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_FIRED = 2'd2;
  localparam logic [1:0] ST_IDLE = 2'd3;

  typedef struct packed {
    logic op;
    logic [DueW-1:0] due_time;
    logic [TagW-1:0] tag;
    logic [DueW-1:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [TagW-1:0] fired_tag;
    logic [DueW-1:0] fired_due;
    logic [OccW-1:0] occupancy;
  } res_t;
endpackage

// File: rtl/min_heap_timer_queue.sv
// Channel  Direction  tdata fields (low bit up)                     tlast/tuser
// s_axis   in         op, due_time, tag, now_time (113 of 120 bits) none
// m_axis   out        status, fired_tag, fired_due, occupancy (73 of 80 bits)  none
// An add sifts up one heap level per cycle.
// A poll that fires steps through DN_RDL, DN_RDR and DN_CMP for each heap
// level sifted down, set by the single read port of the heap memory.
// Reset clears the control state, the count and the queue pointers, not the heap
// memory; a two-item queue lets input run ahead of the heap engine, and the result
// register holds until m_axis_tready, with the next item waiting until it has been taken.
module min_heap_timer_queue (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // op, due_time, tag, now_time
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [79:0] m_axis_tdata    // status, fired_tag, fired_due, occupancy
);
  logic q_valid, q_ready;
  mhtq_pkg::cmd_t q_cmd;
  mhtq_pkg::res_t res;

  mhtq_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  mhtq_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {7'd0, res.occupancy, res.fired_due, res.fired_tag, res.status};
endmodule

// File: rtl/mhtq_front.sv
module mhtq_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [119:0] in_data,
  output logic q_valid,
  input  logic q_ready,
  output mhtq_pkg::cmd_t q_cmd
);
  localparam int Depth = 2;
  mhtq_pkg::cmd_t mem [Depth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [1:0] fill;
  mhtq_pkg::cmd_t cmd;
  logic push, pop;

  always_comb begin
    cmd.op = in_data[0];
    cmd.due_time = in_data[48:1];
    cmd.tag = in_data[64:49];
    cmd.now_time = in_data[112:65];
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_cmd = mem[rd_ptr[0]];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[0]] <= cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/mhtq_back.sv
module mhtq_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  mhtq_pkg::cmd_t q_cmd,
  output logic res_valid,
  input  logic res_ready,
  output mhtq_pkg::res_t res
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROOT = 4'd1;
  localparam logic [3:0] S_UP_RD = 4'd2;
  localparam logic [3:0] S_UP_CMP = 4'd3;
  localparam logic [3:0] S_LAST_RD = 4'd4;
  localparam logic [3:0] S_DN_RDL = 4'd5;
  localparam logic [3:0] S_DN_RDR = 4'd6;
  localparam logic [3:0] S_DN_CMP = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [mhtq_pkg::DueW+mhtq_pkg::TagW-1:0] mem [mhtq_pkg::Capacity];
  logic [mhtq_pkg::DueW+mhtq_pkg::TagW-1:0] rd_data;
  logic [mhtq_pkg::AddrW-1:0] rd_addr;
  logic rd_en;
  logic [mhtq_pkg::AddrW-1:0] wr_addr;
  logic [mhtq_pkg::DueW+mhtq_pkg::TagW-1:0] wr_data;
  logic wr_en;

  logic [3:0] state;
  logic [mhtq_pkg::CountW-1:0] count;
  logic [mhtq_pkg::AddrW-1:0] pos;
  logic [mhtq_pkg::CountW:0] left_idx;
  logic [mhtq_pkg::DueW-1:0] cur_due;
  logic [mhtq_pkg::TagW-1:0] cur_tag;
  logic [mhtq_pkg::DueW-1:0] now;
  logic [mhtq_pkg::DueW-1:0] l_due;
  logic [mhtq_pkg::TagW-1:0] l_tag;
  logic l_ok, r_ok;
  logic [mhtq_pkg::DueW-1:0] rd_due;
  logic [mhtq_pkg::TagW-1:0] rd_tag;
  logic [mhtq_pkg::AddrW-1:0] parent;

  assign rd_due = rd_data[mhtq_pkg::DueW+mhtq_pkg::TagW-1:mhtq_pkg::TagW];
  assign rd_tag = rd_data[mhtq_pkg::TagW-1:0];
  assign parent = (pos - 1'b1) >> 1;
  assign left_idx = {1'b0, pos, 1'b1};
  assign q_ready = (state == S_IDLE) && !res_valid;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = pos;
    wr_data = {cur_due, cur_tag};
    unique case (state)
      S_IDLE: begin
        rd_en = 1'b1;
        rd_addr = (q_cmd.op == mhtq_pkg::OP_ADD) ? parent : '0;
        if (q_valid && q_cmd.op == mhtq_pkg::OP_ADD) begin
          rd_addr = (count[mhtq_pkg::AddrW-1:0] - 1'b1) >> 1;
        end
      end
      S_UP_CMP: begin
        if (pos != '0 && rd_due > cur_due) begin
          wr_en = 1'b1;
          wr_data = rd_data;
          rd_en = 1'b1;
          rd_addr = (parent - 1'b1) >> 1;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_ROOT: begin
        rd_en = 1'b1;
        rd_addr = count[mhtq_pkg::AddrW-1:0] - 1'b1;
      end
      S_DN_RDL: begin
        rd_en = 1'b1;
        rd_addr = left_idx[mhtq_pkg::AddrW-1:0];
      end
      S_DN_RDR: begin
        rd_en = 1'b1;
        rd_addr = left_idx[mhtq_pkg::AddrW-1:0] + 1'b1;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (r_ok && rd_due < cur_due && !(l_ok && l_due <= rd_due)) begin
          wr_data = rd_data;
        end else if (l_ok && l_due < cur_due) begin
          wr_data = {l_due, l_tag};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            now <= q_cmd.now_time;
            cur_due <= q_cmd.due_time;
            cur_tag <= q_cmd.tag;
            res.fired_tag <= '0;
            res.fired_due <= '0;
            if (q_cmd.op == mhtq_pkg::OP_ADD) begin
              if (count >= mhtq_pkg::CountW'(mhtq_pkg::Capacity)) begin
                res.status <= mhtq_pkg::ST_FULL;
                state <= S_OUT;
              end else begin
                pos <= count[mhtq_pkg::AddrW-1:0];
                count <= count + 1'b1;
                res.status <= mhtq_pkg::ST_ADDED;
                state <= S_UP_CMP;
              end
            end else if (count == '0) begin
              res.status <= mhtq_pkg::ST_IDLE;
              state <= S_OUT;
            end else begin
              state <= S_ROOT;
            end
          end
        end
        S_UP_CMP: begin
          if (pos != '0 && rd_due > cur_due) begin
            pos <= parent;
          end else begin
            state <= S_OUT;
          end
        end
        S_ROOT: begin
          if (rd_due > now) begin
            res.status <= mhtq_pkg::ST_IDLE;
            state <= S_OUT;
          end else begin
            res.status <= mhtq_pkg::ST_FIRED;
            res.fired_due <= rd_due;
            res.fired_tag <= rd_tag;
            count <= count - 1'b1;
            pos <= '0;
            state <= S_LAST_RD;
          end
        end
        S_LAST_RD: begin
          cur_due <= rd_due;
          cur_tag <= rd_tag;
          state <= S_DN_RDL;
        end
        S_DN_RDL: begin
          l_ok <= left_idx < {1'b0, count};
          r_ok <= (left_idx + 1'b1) < {1'b0, count};
          state <= S_DN_RDR;
        end
        S_DN_RDR: begin
          l_due <= rd_due;
          l_tag <= rd_tag;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (r_ok && rd_due < cur_due && !(l_ok && l_due <= rd_due)) begin
            pos <= left_idx[mhtq_pkg::AddrW-1:0] + 1'b1;
            state <= S_DN_RDL;
          end else if (l_ok && l_due < cur_due) begin
            pos <= left_idx[mhtq_pkg::AddrW-1:0];
            state <= S_DN_RDL;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            res.occupancy <= mhtq_pkg::OccW'(count);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: tb/tb_min_heap_timer_queue.sv
module tb_min_heap_timer_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;

  typedef struct {
    logic [1:0] status;
    logic [mhtq_pkg::TagW-1:0] fired_tag;
    logic [mhtq_pkg::DueW-1:0] fired_due;
    logic [mhtq_pkg::OccW-1:0] occupancy;
  } timer_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  logic [mhtq_pkg::DueW-1:0] model_due [mhtq_pkg::Capacity];
  logic [mhtq_pkg::TagW-1:0] model_tag [mhtq_pkg::Capacity];
  int model_count;
  timer_res_t pending_results[$];
  int errors;
  int cycles;
  int items_sent;
  int fired_seen;
  int full_seen;
  int idle_seen;
  bit stall_enable;

  min_heap_timer_queue dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [mhtq_pkg::DueW-1:0] d;
    logic [mhtq_pkg::TagW-1:0] t;
    d = model_due[a];
    t = model_tag[a];
    model_due[a] = model_due[b];
    model_tag[a] = model_tag[b];
    model_due[b] = d;
    model_tag[b] = t;
  endfunction

  function automatic timer_res_t predict_timer(logic op, logic [mhtq_pkg::DueW-1:0] due,
                                               logic [mhtq_pkg::TagW-1:0] tag,
                                               logic [mhtq_pkg::DueW-1:0] now);
    timer_res_t r;
    int pos;
    int parent;
    int best;
    r.fired_tag = '0;
    r.fired_due = '0;
    if (op == mhtq_pkg::OP_ADD) begin
      if (model_count >= mhtq_pkg::Capacity) begin
        r.status = mhtq_pkg::ST_FULL;
      end else begin
        pos = model_count;
        model_due[pos] = due;
        model_tag[pos] = tag;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (model_due[parent] <= model_due[pos]) break;
          swap_slots(parent, pos);
          pos = parent;
        end
        model_count++;
        r.status = mhtq_pkg::ST_ADDED;
      end
    end else begin
      if (model_count == 0 || model_due[0] > now) begin
        r.status = mhtq_pkg::ST_IDLE;
      end else begin
        r.fired_due = model_due[0];
        r.fired_tag = model_tag[0];
        model_due[0] = model_due[model_count-1];
        model_tag[0] = model_tag[model_count-1];
        model_count--;
        pos = 0;
        forever begin
          best = pos;
          if (2*pos+1 < model_count && model_due[2*pos+1] < model_due[best]) best = 2*pos+1;
          if (2*pos+2 < model_count && model_due[2*pos+2] < model_due[best]) best = 2*pos+2;
          if (best == pos) break;
          swap_slots(best, pos);
          pos = best;
        end
        r.status = mhtq_pkg::ST_FIRED;
      end
    end
    r.occupancy = mhtq_pkg::OccW'(model_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  task automatic send_item(logic op, logic [mhtq_pkg::DueW-1:0] due,
                           logic [mhtq_pkg::TagW-1:0] tag,
                           logic [mhtq_pkg::DueW-1:0] now);
    int g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tdata <= {7'd0, now, tag, due, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_timer(op, due, tag, now));
    items_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    timer_res_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata[63:0], 64'd0);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[1:0] != exp_r.status)
          report_mismatch("status", 64'(m_axis_tdata[1:0]), 64'(exp_r.status));
        if (m_axis_tdata[17:2] != exp_r.fired_tag)
          report_mismatch("fired_tag", 64'(m_axis_tdata[17:2]), 64'(exp_r.fired_tag));
        if (m_axis_tdata[65:18] != exp_r.fired_due)
          report_mismatch("fired_due", 64'(m_axis_tdata[65:18]), 64'(exp_r.fired_due));
        if (m_axis_tdata[72:66] != exp_r.occupancy)
          report_mismatch("occupancy", 64'(m_axis_tdata[72:66]), 64'(exp_r.occupancy));
        if (exp_r.status == mhtq_pkg::ST_FIRED) fired_seen++;
        if (exp_r.status == mhtq_pkg::ST_FULL) full_seen++;
        if (exp_r.status == mhtq_pkg::ST_IDLE) idle_seen++;
      end
    end
  end

  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (!stall_enable) begin
        m_axis_tready <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (g) @(negedge clk);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_extremes();
    send_item(mhtq_pkg::OP_POLL, '0, '0, '1);
    send_item(mhtq_pkg::OP_ADD, '1, '1, '0);
    send_item(mhtq_pkg::OP_POLL, '0, '0, 48'hFFFF_FFFF_FFFE);
    send_item(mhtq_pkg::OP_ADD, '0, '0, '1);
    send_item(mhtq_pkg::OP_ADD, 48'h5, 16'hAAAA, '0);
    send_item(mhtq_pkg::OP_ADD, 48'h5, 16'h5555, '0);
    send_item(mhtq_pkg::OP_ADD, 48'h5, 16'h1234, '0);
    send_item(mhtq_pkg::OP_POLL, '1, '1, '0);
    send_item(mhtq_pkg::OP_POLL, '1, '1, 48'h4);
    send_item(mhtq_pkg::OP_POLL, '1, '1, 48'h5);
    send_item(mhtq_pkg::OP_POLL, '0, '0, 48'h5);
    send_item(mhtq_pkg::OP_POLL, '0, '0, '1);
    send_item(mhtq_pkg::OP_POLL, '0, '0, '1);
    send_item(mhtq_pkg::OP_POLL, '0, '0, '1);
    send_item(mhtq_pkg::OP_POLL, '0, '0, '1);
    wait_drained();
  endtask

  task automatic test_fill_to_capacity();
    for (int i = 0; i < mhtq_pkg::Capacity + 3; i++)
      send_item(mhtq_pkg::OP_ADD, mhtq_pkg::DueW'($urandom_range(0, 15)),
                mhtq_pkg::TagW'($urandom), '0);
    for (int i = 0; i < mhtq_pkg::Capacity + 2; i++)
      send_item(mhtq_pkg::OP_POLL, '0, '0, '1);
    wait_drained();
  endtask

  task automatic test_random_mix(int n);
    logic [mhtq_pkg::DueW-1:0] base;
    logic [mhtq_pkg::DueW-1:0] due;
    logic [mhtq_pkg::DueW-1:0] now;
    logic op;
    int sel;
    base = mhtq_pkg::DueW'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) due = mhtq_pkg::DueW'({$urandom, $urandom});
      else due = base + mhtq_pkg::DueW'($urandom_range(0, 63));
      if (sel == 0) now = mhtq_pkg::DueW'({$urandom, $urandom});
      else now = base + mhtq_pkg::DueW'($urandom_range(0, 70));
      if (model_count > 50) op = ($urandom_range(0, 3) != 0);
      else op = 1'($urandom_range(0, 1));
      send_item(op, due, mhtq_pkg::TagW'($urandom), now);
      if (i % 120 == 60) begin
        wait_drained();
        base = mhtq_pkg::DueW'({$urandom, $urandom});
      end
    end
    wait_drained();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    items_sent = 0;
    fired_seen = 0;
    full_seen = 0;
    idle_seen = 0;
    model_count = 0;
    stall_enable = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    stall_enable = 1'b1;
    test_fill_to_capacity();
    test_random_mix(400);
    stall_enable = 1'b0;
    test_random_mix(150);
    stall_enable = 1'b1;
    test_random_mix(150);
    repeat (50) @(posedge clk);
    $display("Sent %0d items: %0d fired, %0d full rejections, %0d idle polls.",
             items_sent, fired_seen, full_seen, idle_seen);
    $display("Covered ties, capacity limit, empty polls and random stalls on both sides.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/mhtq_pkg.sv
rtl/mhtq_front.sv
rtl/mhtq_back.sv
rtl/min_heap_timer_queue.sv
tb/tb_min_heap_timer_queue.sv
